// File: src/dftc_pkg.sv
// ----------------------------------------------------------------------------
// dftc_pkg: shared definitions for the decimal field type classifier
// Character codes, result limits and the per-field running state record.
// ----------------------------------------------------------------------------
package dftc_pkg;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;

	localparam int DIGIT_CNT_W = 4;
	localparam int MINUS_CNT_W = 2;
	localparam int SHORT_ACC_W = 17;
	localparam int INT_ACC_W   = 30;

	localparam logic [DIGIT_CNT_W-1:0] SHORT_MAX_DIGITS = 4'd5;
	localparam logic [DIGIT_CNT_W-1:0] INT_MAX_DIGITS   = 4'd9;
	localparam logic [DIGIT_CNT_W-1:0] DIGIT_CNT_SAT    = 4'd15;
	localparam logic [MINUS_CNT_W-1:0] MINUS_CNT_SAT    = 2'd3;
	localparam logic [MINUS_CNT_W-1:0] MINUS_MAX        = 2'd1;

	localparam logic [SHORT_ACC_W-1:0] SHORT_LIMIT = 17'd65534;
	localparam logic [15:0] EMPTY_SHORT_VALUE = 16'hFFFF;
	localparam logic [31:0] EMPTY_INT_VALUE   = 32'h8000_0000;

	typedef struct packed {
		logic [DIGIT_CNT_W-1:0] digit_count;
		logic [MINUS_CNT_W-1:0] minus_count;
		logic                   short_ok;
		logic                   integer_ok;
		logic                   numeric_ok;
		logic [SHORT_ACC_W-1:0] short_accum;
		logic [INT_ACC_W-1:0]   integer_accum;
		logic                   leading_minus;
		logic                   prefix_ended;
		logic                   prefix_has_digit;
		logic                   at_field_start;
	} field_state_t;

	localparam field_state_t FIELD_CLEAR = '{
		digit_count:      '0,
		minus_count:      '0,
		short_ok:         1'b1,
		integer_ok:       1'b1,
		numeric_ok:       1'b1,
		short_accum:      '0,
		integer_accum:    '0,
		leading_minus:    1'b0,
		prefix_ended:     1'b0,
		prefix_has_digit: 1'b0,
		at_field_start:   1'b1
	};

endpackage

// File: src/decimal_field_type_classifier_top.sv
// ----------------------------------------------------------------------------
// decimal_field_type_classifier_top: streaming text field classifier
// Classifies one text field as unsigned short, int and numeric-like text.
// ----------------------------------------------------------------------------
// Usage: the characters of one field arrive on the input channel (in_valid,
// in_ready, ch, no_char, last), one word per character. A word with no_char
// set carries no character; with last also set it closes the field, and a
// closing word that follows no character at all marks an empty field. Every
// word with last set produces exactly one result word on the output channel
// (out_valid, out_ready, is_ushort, short_value, is_int, int_value,
// is_numlike); other words produce nothing.
// Flow: a word is captured in the input register at acceptance; from there
// it is folded into the running field state and, for a closing word, loads
// the result register, which a closing word waits for while a result is
// held. Throughput is one word per cycle while no closing word waits; the
// state update holds a multiply by ten done as shift and add.
// Stalls: while out_ready is low and a result waits, words that do not close
// a field keep flowing into the state; the input stalls only once a closing
// word sits in the input register behind the waiting result.
// Reset: arst_n clears both valid flags and returns the field state to the
// start of a field; no result is pending after reset.
// ----------------------------------------------------------------------------
module decimal_field_type_classifier_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	input  logic        no_char,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_ushort,
	output logic [15:0] short_value,
	output logic        is_int,
	output logic signed [31:0] int_value,
	output logic        is_numlike
);
	import dftc_pkg::*;

	// Input register.
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       no_char_s1;
	logic       last_s1;

	// Running state of the field being read.
	field_state_t st_q;
	field_state_t st_nx;

	logic advance;
	logic res_load;
	logic out_free;

	assign out_free = !out_valid || out_ready;
	// The input register empties when its word either updates the state only
	// or its result can go into the result register.
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || advance;
	assign res_load = advance && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s1      <= ch;
			no_char_s1 <= no_char;
			last_s1    <= last;
		end
	end

	// Per-character state update.
	logic                   is_digit;
	logic                   is_minus;
	logic                   in_set;
	logic [3:0]             digit;
	logic [SHORT_ACC_W-1:0] short_x10;
	logic [INT_ACC_W-1:0]   int_x10;

	always_comb begin
		is_digit  = (ch_s1 >= CHAR_ZERO) && (ch_s1 <= CHAR_NINE);
		is_minus  = (ch_s1 == CHAR_MINUS);
		digit     = is_digit ? 4'(ch_s1 - CHAR_ZERO) : 4'd0;
		in_set    = is_digit || is_minus || (ch_s1 == CHAR_COMMA) ||
		            (ch_s1 == CHAR_DOT) || (ch_s1 == CHAR_COLON) ||
		            (ch_s1 == CHAR_SPACE) || (ch_s1 == CHAR_SLASH);
		short_x10 = (st_q.short_accum << 3) + (st_q.short_accum << 1) +
		            SHORT_ACC_W'(digit);
		int_x10   = (st_q.integer_accum << 3) + (st_q.integer_accum << 1) +
		            INT_ACC_W'(digit);

		st_nx = st_q;
		if (!no_char_s1) begin
			if (!in_set) begin
				st_nx.numeric_ok = 1'b0;
			end
			if (is_digit) begin
				if (st_q.digit_count < SHORT_MAX_DIGITS) begin
					st_nx.short_accum = short_x10;
				end
				if (!st_q.prefix_ended) begin
					if (st_q.digit_count < INT_MAX_DIGITS) begin
						st_nx.integer_accum = int_x10;
					end
					st_nx.prefix_has_digit = 1'b1;
				end
				if (st_q.digit_count != DIGIT_CNT_SAT) begin
					st_nx.digit_count = st_q.digit_count + 1'b1;
				end
			end else begin
				st_nx.short_ok = 1'b0;
				if (is_minus) begin
					if (st_q.minus_count != MINUS_CNT_SAT) begin
						st_nx.minus_count = st_q.minus_count + 1'b1;
					end
					if (st_q.at_field_start) begin
						st_nx.leading_minus = 1'b1;
					end else begin
						st_nx.prefix_ended = 1'b1;
					end
				end else begin
					st_nx.integer_ok   = 1'b0;
					st_nx.prefix_ended = 1'b1;
				end
			end
			st_nx.at_field_start = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= FIELD_CLEAR;
		end else if (advance) begin
			st_q <= last_s1 ? FIELD_CLEAR : st_nx;
		end
	end

	// Classification of the finished field.
	logic        s_ok;
	logic        i_ok;
	logic        n_ok;
	logic [15:0] s_val;
	logic [31:0] i_val;
	logic [31:0] i_mag;

	always_comb begin
		i_mag = 32'(st_nx.integer_accum);
		if (st_nx.at_field_start) begin
			s_ok  = 1'b1;
			s_val = EMPTY_SHORT_VALUE;
			i_ok  = 1'b1;
			i_val = EMPTY_INT_VALUE;
			n_ok  = 1'b1;
		end else begin
			s_ok  = st_nx.short_ok && (st_nx.digit_count != '0) &&
			        (st_nx.digit_count <= SHORT_MAX_DIGITS) &&
			        (st_nx.short_accum <= SHORT_LIMIT);
			s_val = s_ok ? st_nx.short_accum[15:0] : 16'd0;
			i_ok  = st_nx.integer_ok && (st_nx.digit_count <= INT_MAX_DIGITS) &&
			        (st_nx.minus_count <= MINUS_MAX) && st_nx.prefix_has_digit;
			i_val = !i_ok ? 32'd0 : (st_nx.leading_minus ? (32'd0 - i_mag) : i_mag);
			n_ok  = st_nx.numeric_ok;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			is_ushort   <= s_ok;
			short_value <= s_val;
			is_int      <= i_ok;
			int_value   <= signed'(i_val);
			is_numlike  <= n_ok;
		end
	end

	// A failed check always reports a zero value.
	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_ushort) |-> (short_value == 16'd0))
		else $error("short_value nonzero on failed short check");

	a_int_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_int) |-> (int_value == 32'sd0))
		else $error("int_value nonzero on failed int check");

	// A valid short consists of digits only, so it is also numeric-like.
	a_short_numeric: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_ushort) |-> is_numlike)
		else $error("short field reported as not numeric");

	// Closing a field returns the state to the start of a field.
	a_field_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> (st_q.at_field_start && st_q.digit_count == '0 &&
		              st_q.minus_count == '0))
		else $error("field state not cleared after result");

endmodule

// File: tb/decimal_field_type_classifier_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_field_type_classifier_top_tb: self-checking bench for the classifier
// Streams text fields into the block one character word at a time, predicts
// each classification in step with the accepted words, and checks every
// result word, field by field, against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module decimal_field_type_classifier_top_tb;

	import dftc_pkg::*;

	// The watchdog gives up after this many cycles in which no word moves on
	// either channel.
	localparam int STALL_LIMIT   = 4000;
	localparam int RANDOM_WORDS  = 1150;
	localparam int SETTLE_CYCLES = 12;

	// One classification, as the block reports it on the result channel.
	typedef struct {
		logic        is_ushort;
		logic [15:0] short_value;
		logic        is_int;
		logic [31:0] int_value;
		logic        is_numlike;
	} field_class_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  ch = 8'h00;
	logic        no_char = 1'b0;
	logic        last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        is_ushort;
	logic [15:0] short_value;
	logic        is_int;
	logic signed [31:0] int_value;
	logic        is_numlike;

	decimal_field_type_classifier_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.ch         (ch),
		.no_char    (no_char),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.is_ushort  (is_ushort),
		.short_value(short_value),
		.is_int     (is_int),
		.int_value  (int_value),
		.is_numlike (is_numlike)
	);

	// Classifications predicted for closed fields, oldest first.
	field_class_t pending_classes[$];

	int error_count = 0;
	int words_sent = 0;
	int idle_cycles = 0;
	// When set, neither side idles: words go in at the full rate of one per
	// cycle and the result side keeps ready high.
	bit full_rate = 1'b0;

	// Running picture of the field being received, kept by the predictor.
	logic [3:0]  seen_digits;
	logic [1:0]  seen_minus;
	logic        short_fit;
	logic        int_fit;
	logic        numeric_fit;
	logic [16:0] short_acc;
	logic [29:0] int_acc;
	logic        neg_lead;
	logic        prefix_done;
	logic        prefix_digit;
	logic        field_empty;

	initial begin
		forever #4 clk = ~clk;
	end

	// Start of a new field: nothing seen yet, every check still possible.
	function automatic void restart_field();
		seen_digits = '0;
		seen_minus = '0;
		short_fit = 1'b1;
		int_fit = 1'b1;
		numeric_fit = 1'b1;
		short_acc = '0;
		int_acc = '0;
		neg_lead = 1'b0;
		prefix_done = 1'b0;
		prefix_digit = 1'b0;
		field_empty = 1'b1;
	endfunction

	// Folds one accepted word into the running field picture and, for a word
	// that closes the field, queues the classification the block must report.
	function automatic void classify_word(input logic [7:0] c, input logic nc,
		input logic lst);
		logic         is_digit;
		logic         is_minus;
		logic [3:0]   value;
		field_class_t verdict;
		if (!nc) begin
			is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
			is_minus = (c == CHAR_MINUS);
			value = is_digit ? 4'(c - CHAR_ZERO) : 4'd0;
			if (!(is_digit || is_minus || c == CHAR_COMMA || c == CHAR_DOT ||
					c == CHAR_COLON || c == CHAR_SPACE || c == CHAR_SLASH)) begin
				numeric_fit = 1'b0;
			end
			if (is_digit) begin
				// Only the first five digits feed the short value and only the
				// first nine the int value; later digits just count.
				if (seen_digits < 4'd5) begin
					short_acc = 17'(short_acc * 17'd10 + 17'(value));
				end
				if (!prefix_done) begin
					if (seen_digits < 4'd9) begin
						int_acc = 30'(int_acc * 30'd10 + 30'(value));
					end
					prefix_digit = 1'b1;
				end
				if (seen_digits != 4'd15) begin
					seen_digits = seen_digits + 4'd1;
				end
			end else begin
				short_fit = 1'b0;
				if (is_minus) begin
					if (seen_minus != 2'd3) begin
						seen_minus = seen_minus + 2'd1;
					end
					// A minus up front is a sign; anywhere else it ends the
					// digit run that the int value is read from.
					if (field_empty) begin
						neg_lead = 1'b1;
					end else begin
						prefix_done = 1'b1;
					end
				end else begin
					int_fit = 1'b0;
					prefix_done = 1'b1;
				end
			end
			field_empty = 1'b0;
		end
		if (lst) begin
			if (field_empty) begin
				verdict = '{1'b1, EMPTY_SHORT_VALUE, 1'b1, EMPTY_INT_VALUE, 1'b1};
			end else begin
				verdict.is_ushort = short_fit && seen_digits >= 4'd1 &&
					seen_digits <= 4'd5 && short_acc <= 17'd65534;
				verdict.short_value = verdict.is_ushort ? short_acc[15:0] : 16'd0;
				verdict.is_int = int_fit && seen_digits <= 4'd9 &&
					seen_minus <= 2'd1 && prefix_digit;
				verdict.int_value = !verdict.is_int ? 32'd0 :
					neg_lead ? 32'd0 - {2'b00, int_acc} : {2'b00, int_acc};
				verdict.is_numlike = numeric_fit;
			end
			pending_classes.insert(pending_classes.size(), verdict);
			restart_field();
		end
	endfunction

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (full_rate || r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// Offers one word and holds it until the block takes it, then lets the
	// sender idle for a random while.
	task automatic send_word(input logic [7:0] c, input logic nc, input logic lst);
		int gap;
		in_valid <= 1'b1;
		ch <= c;
		no_char <= nc;
		last <= lst;
		do begin
			@(posedge clk);
		end while (!in_ready);
		classify_word(c, nc, lst);
		// A word with no character that does not close the field is ignored
		// by the block, so it does not count toward the stimulus.
		if (!nc || lst) begin
			words_sent++;
		end
		gap = idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sends a whole field. It closes either on its final character or on an
	// extra word that carries no character. Empty words are sprinkled in,
	// each with a random byte that the block must ignore.
	task automatic send_text(input string text, input bit close_empty);
		int i;
		bit closing;
		closing = close_empty || text.len() == 0;
		for (i = 0; i < text.len(); i++) begin
			if ($urandom_range(0, 9) == 0) begin
				send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
			end
			send_word(text[i], 1'b0, !closing && i == text.len() - 1);
		end
		if (closing) begin
			send_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
		end
	endtask

	function automatic string digit_text(input int count);
		string s;
		int i;
		s = "";
		for (i = 0; i < count; i++) begin
			s = {s, string'(8'("0" + $urandom_range(0, 9)))};
		end
		return s;
	endfunction

	// The sender holds off until every closed field has been reported.
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending_classes.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic apply_reset();
		restart_field();
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	// Empty fields, alone and after ignored words, and a field that closes on
	// a word without a character.
	task automatic test_empty_fields();
		send_text("", 1'b1);
		send_word(8'hFF, 1'b1, 1'b0);
		send_word(8'h00, 1'b1, 1'b1);
		send_text("7", 1'b1);
	endtask

	// The short value on both sides of its limit.
	task automatic test_short_limits();
		send_text("65534", 1'b0);
		send_text("65535", 1'b0);
		send_text("0", 1'b0);
	endtask

	// Sign handling in the int prefix: minus zero, a minus inside the field,
	// two minus signs, and a lone minus with no digit after it.
	task automatic test_int_prefix();
		send_text("-0", 1'b0);
		send_text("1-2", 1'b0);
		send_text("--5", 1'b0);
		send_text("-", 1'b0);
	endtask

	// Every separator of the numeric-like set, then bytes outside every set,
	// the high ones among them.
	task automatic test_char_classes();
		send_text("9,.: /", 1'b0);
		send_word(8'h80, 1'b0, 1'b0);
		send_word(8'hFF, 1'b0, 1'b1);
		send_word(8'h00, 1'b0, 1'b1);
		send_word(8'h7F, 1'b0, 1'b1);
	endtask

	// Back-to-back words and results with neither side idling, then a pause
	// until everything has drained.
	task automatic test_full_rate();
		int i;
		full_rate = 1'b1;
		for (i = 0; i < 25; i++) begin
			send_text(digit_text($urandom_range(1, 5)), 1'b0);
		end
		full_rate = 1'b0;
		wait_drain();
	endtask

	// Mostly well-formed fields with random content, some of them long or
	// close to a limit, and a share of noise.
	task automatic test_random_fields();
		int r;
		int n;
		int i;
		string text;
		string numeric_set;
		numeric_set = "0123456789,.: /-";
		while (words_sent < RANDOM_WORDS) begin
			r = $urandom_range(0, 99);
			text = "";
			if (r < 28) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 17) :
					$urandom_range(1, 5);
				text = digit_text(n);
			end else if (r < 42) begin
				text = {"-", digit_text($urandom_range(1, 10))};
			end else if (r < 52) begin
				text = $sformatf("%0d", $urandom_range(65400, 65535));
			end else if (r < 60) begin
				text = $sformatf("%s%0d", $urandom_range(0, 1) ? "-" : "",
					$urandom_range(100000000, 999999999));
			end else if (r < 70) begin
				text = {digit_text($urandom_range(0, 4)), "-",
					digit_text($urandom_range(0, 4))};
			end else if (r < 80) begin
				n = $urandom_range(1, 8);
				for (i = 0; i < n; i++) begin
					text = {text, string'(numeric_set[$urandom_range(0, 15)])};
				end
			end else if (r < 92) begin
				// Raw bytes of any value, NUL included, so they go out word by
				// word rather than as text.
				n = $urandom_range(1, 6);
				for (i = 0; i < n; i++) begin
					send_word(8'($urandom_range(0, 255)), 1'b0, i == n - 1);
				end
				continue;
			end
			send_text(text, $urandom_range(0, 4) == 0);
			if ($urandom_range(0, 199) == 0) begin
				wait_drain();
			end
		end
	endtask

	// Result side: ready drops for random stretches, except at full rate.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = idle_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat (full_rate ? 1 : $urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Every accepted result word is matched against the oldest prediction.
	always @(posedge clk) begin
		field_class_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_classes.size() == 0) begin
				$error("result word arrived with no field waiting for one");
				error_count++;
			end else begin
				want = pending_classes.pop_front();
				if (is_ushort !== want.is_ushort) begin
					$error("is_ushort: expected %0d, got %0d", want.is_ushort,
						is_ushort);
					error_count++;
				end
				if (short_value !== want.short_value) begin
					$error("short_value: expected %0d, got %0d", want.short_value,
						short_value);
					error_count++;
				end
				if (is_int !== want.is_int) begin
					$error("is_int: expected %0d, got %0d", want.is_int, is_int);
					error_count++;
				end
				if (int_value !== want.int_value) begin
					$error("int_value: expected %0d, got %0d",
						$signed(want.int_value), int_value);
					error_count++;
				end
				if (is_numlike !== want.is_numlike) begin
					$error("is_numlike: expected %0d, got %0d", want.is_numlike,
						is_numlike);
					error_count++;
				end
			end
		end
	end

	// Watchdog: a run in which no word moves for too long has hung.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		apply_reset();
		test_empty_fields();
		test_short_limits();
		test_int_prefix();
		test_char_classes();
		test_full_rate();
		test_random_fields();
		wait_drain();
		// Any result word beyond the last prediction would show up here.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_classes.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
